// ===== hw/rtl/box_volume_sorter_macros.svh =====
// Assertion macros shared by the box volume sorter RTL.
`ifndef BOX_VOLUME_SORTER_MACROS_SVH
`define BOX_VOLUME_SORTER_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define BVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define BVS_NEVER(lbl, cond, msg) \
  `BVS_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/bvs_pkg.sv =====
// Types and constants of the box volume sorter.
package bvs_pkg;

  localparam int DIM_W = 16;
  localparam int VOL_W = 48;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [VOL_W-1:0] vol_t;

  typedef struct packed {
    dim_t length;
    dim_t breadth;
    dim_t height;
    vol_t volume;
  } box_rec_t;

  localparam int REC_W = $bits(box_rec_t);

endpackage

// ===== hw/rtl/bvs_in_if.sv =====
// Input channel: one box per item.
interface bvs_in_if;
  import bvs_pkg::*;

  logic valid;
  logic ready;
  dim_t box_length;
  dim_t box_breadth;
  dim_t box_height;
  logic final_box;

  modport source (output valid, box_length, box_breadth, box_height, final_box,
                  input ready);
  modport sink   (input valid, box_length, box_breadth, box_height, final_box,
                  output ready);
endinterface

// ===== hw/rtl/bvs_out_if.sv =====
// Result channel: one sorted box record per item.
interface bvs_out_if;
  import bvs_pkg::*;

  logic valid;
  logic ready;
  dim_t out_length;
  dim_t out_breadth;
  dim_t out_height;
  vol_t out_volume;
  logic end_of_run;
  logic overflowed;

  modport source (output valid, out_length, out_breadth, out_height, out_volume,
                  end_of_run, overflowed, input ready);
  modport sink   (input valid, out_length, out_breadth, out_height, out_volume,
                  end_of_run, overflowed, output ready);
endinterface

// ===== hw/rtl/bvs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bvs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/box_volume_sorter.sv =====
// Box volume sorter: loads boxes, sorts them by non-increasing volume, emits them.
// Each box is loaded through capture, a first multiply, then a second multiply and store.
// The final box starts a sort of the stored boxes, paced by the single read and single
// write port of the record RAM; then each record is read out and held until it is taken.
// No new box is accepted while a box is loaded or a batch is sorted or emitted.
// Reset (rst_n low, synchronous) empties the store, clears the drop flag and output valid.
`include "box_volume_sorter_macros.svh"

module box_volume_sorter #(
  parameter int CAPACITY = 16,
  parameter int DIM_BITS = 16
) (
  input logic     clk,
  input logic     rst_n,
  bvs_in_if.sink  in_box,
  bvs_out_if.source out_box
);
  import bvs_pkg::*;

  // Index width for the record RAM and a counter wide enough to hold CAPACITY itself.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

  // Dimensions keep only their low DIM_BITS bits; above the port width nothing is lost.
  localparam int DMW = (DIM_BITS < DIM_W) ? DIM_BITS : DIM_W;
  localparam logic [DIM_W:0] MASK_WIDE = ((DIM_W+1)'(1) << DMW) - (DIM_W+1)'(1);
  localparam dim_t DIM_MASK = MASK_WIDE[DIM_W-1:0];

  // Sequencer states.
  localparam logic [3:0] S_IN    = 4'd0;  // waiting for a box
  localparam logic [3:0] S_MUL   = 4'd1;  // length times breadth
  localparam logic [3:0] S_WR    = 4'd2;  // times height, store the record
  localparam logic [3:0] S_RDI   = 4'd3;  // read the first pivot entry
  localparam logic [3:0] S_LATCH = 4'd4;  // capture pivot, start the inner scan
  localparam logic [3:0] S_SCAN  = 4'd5;  // compare and swap against entry j
  localparam logic [3:0] S_WB    = 4'd6;  // write pivot back, read the next one
  localparam logic [3:0] S_ORD   = 4'd7;  // read record k for output
  localparam logic [3:0] S_OLD   = 4'd8;  // load the output register
  localparam logic [3:0] S_OWAIT = 4'd9;  // hold the record until it is taken

  // Control state.
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Working and payload registers.
  dim_t          len_r, len_nxt;
  dim_t          brd_r, brd_nxt;
  dim_t          hgt_r, hgt_nxt;
  logic          last_r, last_nxt;
  logic [31:0]   area_r, area_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] pend_j_r, pend_j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  box_rec_t      piv_r, piv_nxt;
  box_rec_t      out_rec_r, out_rec_nxt;
  logic          out_eor_r, out_eor_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  // Record RAM ports.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  box_rec_t        ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [REC_W-1:0] ram_rdata;
  box_rec_t        rd_rec;

  logic [CW-1:0] i_inc;
  logic          in_fire;
  logic          swap;

  assign rd_rec  = box_rec_t'(ram_rdata);
  assign in_fire = in_box.valid && in_box.ready;
  assign i_inc   = i_r + CW'(1);

  // Entry i is held in piv_r during its scan, so the RAM copy of entry i is stale;
  // the scan skips it, which is safe because equal volumes never swap.
  // The write of entry j always targets the address whose data is on the read port,
  // while the read port has moved on to j+1, so no read ever races a write to the same entry.
  assign swap = (pend_j_r != i_r) && (rd_rec.volume < piv_r.volume);

  bvs_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    len_nxt       = len_r;
    brd_nxt       = brd_r;
    hgt_nxt       = hgt_r;
    last_nxt      = last_r;
    area_nxt      = area_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pend_j_nxt    = pend_j_r;
    k_nxt         = k_r;
    piv_nxt       = piv_r;
    out_rec_nxt   = out_rec_r;
    out_eor_nxt   = out_eor_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = piv_r;
    ram_raddr     = '0;

    case (state_r)
      S_IN: begin
        if (in_fire) begin
          len_nxt   = in_box.box_length & DIM_MASK;
          brd_nxt   = in_box.box_breadth & DIM_MASK;
          hgt_nxt   = in_box.box_height & DIM_MASK;
          last_nxt  = in_box.final_box;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        area_nxt  = 32'(len_r) * 32'(brd_r);
        state_nxt = S_WR;
      end
      S_WR: begin
        if (count_r < CNT_CAP) begin
          ram_we           = 1'b1;
          ram_waddr        = count_r[AW-1:0];
          ram_wdata.length  = len_r;
          ram_wdata.breadth = brd_r;
          ram_wdata.height  = hgt_r;
          ram_wdata.volume  = VOL_W'(area_r) * VOL_W'(hgt_r);
          count_nxt        = count_r + CW'(1);
        end else begin
          drop_nxt = 1'b1;
        end
        i_nxt     = '0;
        state_nxt = last_r ? S_RDI : S_IN;
      end
      S_RDI: begin
        ram_raddr = '0;
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        piv_nxt    = rd_rec;
        ram_raddr  = '0;
        pend_j_nxt = '0;
        j_nxt      = CW'(1);
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (swap) begin
          ram_we    = 1'b1;
          ram_waddr = pend_j_r[AW-1:0];
          ram_wdata = piv_r;
          piv_nxt   = rd_rec;
        end
        if (j_r < count_r) begin
          ram_raddr  = j_r[AW-1:0];
          pend_j_nxt = j_r;
          j_nxt      = j_r + CW'(1);
        end else begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        ram_wdata = piv_r;
        i_nxt     = i_inc;
        if (i_inc == count_r) begin
          k_nxt     = '0;
          state_nxt = S_ORD;
        end else begin
          ram_raddr = i_inc[AW-1:0];
          state_nxt = S_LATCH;
        end
      end
      S_ORD: begin
        ram_raddr = k_r[AW-1:0];
        state_nxt = S_OLD;
      end
      S_OLD: begin
        out_rec_nxt   = rd_rec;
        out_eor_nxt   = (k_r + CW'(1)) == count_r;
        out_ovf_nxt   = drop_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_box.ready) begin
          out_valid_nxt = 1'b0;
          if (out_eor_r) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_IN;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    brd_r     <= brd_nxt;
    hgt_r     <= hgt_nxt;
    last_r    <= last_nxt;
    area_r    <= area_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    pend_j_r  <= pend_j_nxt;
    k_r       <= k_nxt;
    piv_r     <= piv_nxt;
    out_rec_r <= out_rec_nxt;
    out_eor_r <= out_eor_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  // A box is taken only while the sequencer waits for one.
  assign in_box.ready = (state_r == S_IN);

  assign out_box.valid       = out_valid_r;
  assign out_box.out_length  = out_rec_r.length;
  assign out_box.out_breadth = out_rec_r.breadth;
  assign out_box.out_height  = out_rec_r.height;
  assign out_box.out_volume  = out_rec_r.volume;
  assign out_box.end_of_run  = out_eor_r;
  assign out_box.overflowed  = out_ovf_r;

  `BVS_ASSERT(a_count_bound, count_r <= CNT_CAP, "box count above capacity")
  `BVS_ASSERT(a_accept_to_mul, in_fire |=> (state_r == S_MUL),
              "accepted box not multiplied")
  `BVS_ASSERT(a_batch_clears,
              (out_box.valid && out_box.ready && out_box.end_of_run)
                |=> (count_r == '0 && !drop_r),
              "batch not cleared after last record")
  `BVS_NEVER(a_no_write_on_output,
             ram_we && (state_r == S_ORD || state_r == S_OLD || state_r == S_OWAIT),
             "record RAM written during output")

endmodule
